// ----- rtl/cll_pkg.sv -----
package cll_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_NEXT   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PREV   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_READ_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_PREV   = 3'd3,
    CMD_READ   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_NOP    = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [VALUE_W-1:0] value;
  } queue_entry_t;

endpackage

// ----- rtl/circular_list_with_cursor.sv -----
// Circular doubly linked list with a cursor, up to CAPACITY entries. A command
// is taken when start is high and busy is low; it passes through a two-entry
// queue to the executor, and busy is high only while that queue is full.
// Results leave in command order, one per command, each on the out_ ports for
// exactly one cycle with out_valid high; they cannot be held off, so take every
// transfer when it appears. The executor finishes read, clear, unused opcodes,
// a refused push and delete/next/prev on an empty list in ST_DECODE; a push
// into an empty list or delete of the last entry in ST_LINK; push through
// ST_LINK and ST_WR2; next and prev through ST_LINK and ST_VAL; and delete
// through ST_LINK, ST_WR2 and ST_VAL. These steps follow from the registered
// reads and single write port of the link memories. A result is on the out_
// ports in the cycle after the executor's last state.
// The slot memories need no clearing after reset or clear.
module circular_list_with_cursor #(
  parameter int CAPACITY   = cll_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cll_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic signed [cll_pkg::VALUE_W-1:0]  in_element_value,
  output logic                                out_valid,
  output logic signed [cll_pkg::VALUE_W-1:0]  out_cursor_value,
  output logic                                out_list_empty,
  output logic [cll_pkg::STATUS_W-1:0]        out_status,
  output logic [cll_pkg::COUNT_OUT_W-1:0]     out_element_count
);

  logic                  q_full, q_push, q_valid, q_pop;
  cll_pkg::queue_entry_t q_wr_entry, q_rd_entry;

  cll_front u_front (
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_element_value (in_element_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_wr_entry)
  );

  cll_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_push),
    .wr_data   (q_wr_entry),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_data   (q_rd_entry),
    .not_empty (q_valid)
  );

  cll_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_rd_entry),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_cursor_value  (out_cursor_value),
    .out_list_empty    (out_list_empty),
    .out_status        (out_status),
    .out_element_count (out_element_count)
  );

endmodule

// ----- rtl/cll_front.sv -----
module cll_front (
  input  logic                           start,
  output logic                           busy,
  input  logic [cll_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic signed [cll_pkg::VALUE_W-1:0] in_element_value,
  input  logic                           q_full,
  output logic                           q_push,
  output cll_pkg::queue_entry_t          q_entry
);

  cll_pkg::cmd_t cmd;

  always_comb begin
    case (in_opcode)
      cll_pkg::OP_PUSH:   cmd = cll_pkg::CMD_PUSH;
      cll_pkg::OP_DELETE: cmd = cll_pkg::CMD_DELETE;
      cll_pkg::OP_NEXT:   cmd = cll_pkg::CMD_NEXT;
      cll_pkg::OP_PREV:   cmd = cll_pkg::CMD_PREV;
      cll_pkg::OP_READ:   cmd = cll_pkg::CMD_READ;
      cll_pkg::OP_CLEAR:  cmd = cll_pkg::CMD_CLEAR;
      default:            cmd = cll_pkg::CMD_NOP;
    endcase
  end

  assign busy          = q_full;
  assign q_push        = start && !q_full;
  assign q_entry.cmd   = cmd;
  assign q_entry.value = in_element_value;

endmodule

// ----- rtl/cll_queue.sv -----
module cll_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  cll_pkg::queue_entry_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output cll_pkg::queue_entry_t rd_data,
  output logic                  not_empty
);

  localparam int PTR_W = $clog2(cll_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cll_pkg::QUEUE_DEPTH + 1);

  cll_pkg::queue_entry_t entries_r [cll_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full      = (cnt_r == CNT_W'(cll_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(cll_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(cll_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/cll_back.sv -----
module cll_back #(
  parameter int CAPACITY   = cll_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  cll_pkg::queue_entry_t                  q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  output logic signed [cll_pkg::VALUE_W-1:0]     out_cursor_value,
  output logic                                   out_list_empty,
  output logic [cll_pkg::STATUS_W-1:0]           out_status,
  output logic [cll_pkg::COUNT_OUT_W-1:0]        out_element_count
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_DECODE = 4'b0001,
    ST_LINK   = 4'b0010,
    ST_WR2    = 4'b0100,
    ST_VAL    = 4'b1000
  } state_t;

  logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
  logic [SLOT_W-1:0]     next_mem  [CAPACITY];
  logic [SLOT_W-1:0]     prev_mem  [CAPACITY];

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     first_r, first_nxt;
  logic [SLOT_W-1:0]     cursor_r, cursor_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      fresh_r, fresh_nxt;
  logic [SLOT_W-1:0]     free_head_r, free_head_nxt;
  logic [CNT_W-1:0]      free_size_r, free_size_nxt;
  logic [DATA_WIDTH-1:0] cur_val_r, cur_val_nxt;
  cll_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;

  logic [SLOT_W-1:0]     rd_next_r, rd_prev_r;
  logic [DATA_WIDTH-1:0] rd_value_r;

  logic                  link_re;
  logic [SLOT_W-1:0]     nx_raddr, pv_raddr;
  logic                  nx_we, pv_we, v_we, v_re;
  logic [SLOT_W-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata, v_waddr, v_raddr;
  logic [SLOT_W-1:0]     new_slot, new_first;
  logic                  is_empty, is_full, done;
  logic [cll_pkg::STATUS_W-1:0] status_nxt;
  logic signed [63:0]    cur_ext;

  logic                  out_valid_r;
  logic signed [cll_pkg::VALUE_W-1:0]  out_cursor_value_r;
  logic                  out_list_empty_r;
  logic [cll_pkg::STATUS_W-1:0]        out_status_r;
  logic [cll_pkg::COUNT_OUT_W-1:0]     out_element_count_r;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign new_slot  = (free_size_r != '0) ? free_head_r : SLOT_W'(fresh_r);
  assign new_first = (cursor_r == first_r) ? rd_next_r : first_r;
  assign q_pop     = (state_r == ST_DECODE) && q_valid;
  assign nx_raddr  = (q_data.cmd == cll_pkg::CMD_PUSH) ? free_head_r : cursor_r;
  assign pv_raddr  = (q_data.cmd == cll_pkg::CMD_PUSH) ? first_r : cursor_r;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    free_size_nxt = free_size_r;
    cur_val_nxt   = cur_val_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    slot_nxt      = slot_r;
    link_re       = 1'b0;
    v_re          = 1'b0;
    v_raddr       = cursor_r;
    nx_we         = 1'b0;
    nx_waddr      = cursor_r;
    nx_wdata      = free_head_r;
    pv_we         = 1'b0;
    pv_waddr      = cursor_r;
    pv_wdata      = cursor_r;
    v_we          = 1'b0;
    v_waddr       = new_slot;
    done          = 1'b0;
    status_nxt    = cll_pkg::STATUS_OK;

    case (state_r)
      ST_DECODE: begin
        if (q_valid) begin
          cmd_nxt = q_data.cmd;
          val_nxt = DATA_WIDTH'({32'b0, q_data.value});
          case (q_data.cmd)
            cll_pkg::CMD_PUSH: begin
              if (is_full) begin
                done       = 1'b1;
                status_nxt = cll_pkg::STATUS_FULL;
              end else begin
                link_re   = 1'b1;
                state_nxt = ST_LINK;
              end
            end
            cll_pkg::CMD_DELETE, cll_pkg::CMD_NEXT, cll_pkg::CMD_PREV: begin
              if (is_empty) begin
                done = 1'b1;
              end else begin
                link_re   = 1'b1;
                state_nxt = ST_LINK;
              end
            end
            cll_pkg::CMD_READ: begin
              done       = 1'b1;
              status_nxt = is_empty ? cll_pkg::STATUS_READ_EMPTY : cll_pkg::STATUS_OK;
            end
            cll_pkg::CMD_CLEAR: begin
              count_nxt     = '0;
              fresh_nxt     = '0;
              free_size_nxt = '0;
              free_head_nxt = '0;
              first_nxt     = '0;
              cursor_nxt    = '0;
              done          = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_LINK: begin
        case (cmd_r)
          cll_pkg::CMD_PUSH: begin
            if (free_size_r != '0) begin
              free_head_nxt = rd_next_r;
              free_size_nxt = free_size_r - CNT_W'(1);
            end else begin
              fresh_nxt = fresh_r + CNT_W'(1);
            end
            v_we        = 1'b1;
            nx_we       = 1'b1;
            nx_waddr    = new_slot;
            nx_wdata    = is_empty ? new_slot : first_r;
            pv_we       = 1'b1;
            pv_waddr    = new_slot;
            pv_wdata    = is_empty ? new_slot : rd_prev_r;
            cursor_nxt  = new_slot;
            cur_val_nxt = val_r;
            count_nxt   = count_r + CNT_W'(1);
            slot_nxt    = new_slot;
            if (is_empty) begin
              first_nxt = new_slot;
              done      = 1'b1;
              state_nxt = ST_DECODE;
            end else begin
              state_nxt = ST_WR2;
            end
          end
          cll_pkg::CMD_DELETE: begin
            if (count_r == CNT_W'(1)) begin
              nx_we         = 1'b1;
              free_head_nxt = cursor_r;
              free_size_nxt = free_size_r + CNT_W'(1);
              count_nxt     = '0;
              first_nxt     = '0;
              cursor_nxt    = '0;
              done          = 1'b1;
              state_nxt     = ST_DECODE;
            end else begin
              nx_we     = 1'b1;
              nx_waddr  = rd_prev_r;
              nx_wdata  = rd_next_r;
              pv_we     = 1'b1;
              pv_waddr  = rd_next_r;
              pv_wdata  = rd_prev_r;
              state_nxt = ST_WR2;
            end
          end
          cll_pkg::CMD_NEXT: begin
            cursor_nxt = rd_next_r;
            v_re       = 1'b1;
            v_raddr    = rd_next_r;
            state_nxt  = ST_VAL;
          end
          cll_pkg::CMD_PREV: begin
            cursor_nxt = rd_prev_r;
            v_re       = 1'b1;
            v_raddr    = rd_prev_r;
            state_nxt  = ST_VAL;
          end
          default: begin
            state_nxt = ST_DECODE;
          end
        endcase
      end

      ST_WR2: begin
        case (cmd_r)
          cll_pkg::CMD_PUSH: begin
            // close the ring: old tail and head point at the new entry
            nx_we     = 1'b1;
            nx_waddr  = rd_prev_r;
            nx_wdata  = slot_r;
            pv_we     = 1'b1;
            pv_waddr  = first_r;
            pv_wdata  = slot_r;
            done      = 1'b1;
            state_nxt = ST_DECODE;
          end
          cll_pkg::CMD_DELETE: begin
            nx_we         = 1'b1;
            free_head_nxt = cursor_r;
            free_size_nxt = free_size_r + CNT_W'(1);
            count_nxt     = count_r - CNT_W'(1);
            first_nxt     = new_first;
            cursor_nxt    = new_first;
            v_re          = 1'b1;
            v_raddr       = new_first;
            state_nxt     = ST_VAL;
          end
          default: begin
            state_nxt = ST_DECODE;
          end
        endcase
      end

      ST_VAL: begin
        cur_val_nxt = rd_value_r;
        done        = 1'b1;
        state_nxt   = ST_DECODE;
      end

      default: begin
        state_nxt = ST_DECODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    if (link_re) begin
      rd_next_r <= next_mem[nx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
    if (link_re) begin
      rd_prev_r <= prev_mem[pv_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      value_mem[v_waddr] <= val_r;
    end
    if (v_re) begin
      rd_value_r <= value_mem[v_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DECODE;
      first_r     <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
      free_size_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
      free_size_r <= free_size_nxt;
      out_valid_r <= done;
    end
  end

  assign cur_ext = 64'($signed(cur_val_nxt));

  always_ff @(posedge clk) begin
    cur_val_r <= cur_val_nxt;
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    slot_r    <= slot_nxt;
    if (done) begin
      out_cursor_value_r  <= (count_nxt == '0) ? '0 : cur_ext[cll_pkg::VALUE_W-1:0];
      out_list_empty_r    <= (count_nxt == '0);
      out_status_r        <= status_nxt;
      out_element_count_r <= cll_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_value  = out_cursor_value_r;
  assign out_list_empty    = out_list_empty_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_element_count_r;

endmodule

// ----- bench/cll_result_checker.sv -----
module cll_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [cll_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic signed [cll_pkg::VALUE_W-1:0]  in_element_value,
  input  logic                                out_valid,
  input  logic signed [cll_pkg::VALUE_W-1:0]  out_cursor_value,
  input  logic                                out_list_empty,
  input  logic [cll_pkg::STATUS_W-1:0]        out_status,
  input  logic [cll_pkg::COUNT_OUT_W-1:0]     out_element_count,
  output int unsigned                         fail_count,
  output int unsigned                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import cll_pkg::*;

  localparam int SLOTS  = CAPACITY_DEF;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [COUNT_OUT_W-1:0] count_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cursor_value;
    logic                      list_empty;
    logic [STATUS_W-1:0]       status;
    count_t                    element_count;
  } list_report_t;

  logic [VALUE_W-1:0] slot_value [SLOTS];
  slot_t              fwd_link   [SLOTS];
  slot_t              back_link  [SLOTS];
  slot_t              head_slot;
  slot_t              cur_slot;
  slot_t              free_head;
  count_t             live_count;
  count_t             fresh_count;
  count_t             free_count;

  list_report_t pending_reports [$];
  int unsigned  errors = 0;

  function automatic void clear_list();
    head_slot   = '0;
    cur_slot    = '0;
    free_head   = '0;
    live_count  = '0;
    fresh_count = '0;
    free_count  = '0;
  endfunction

  function automatic list_report_t apply_list_op(logic [OPCODE_W-1:0] op,
                                                 logic [VALUE_W-1:0] value);
    list_report_t rep;
    logic [STATUS_W-1:0] st;
    slot_t s;
    slot_t tail;
    slot_t p;
    slot_t n;
    st = STATUS_OK;
    case (op)
      OP_PUSH: begin
        if (live_count == SLOTS) begin
          st = STATUS_FULL;
        end else begin
          if (free_count != 0) begin
            s = free_head;
            free_head = fwd_link[s];
            free_count--;
          end else begin
            s = fresh_count[SLOT_W-1:0];
            fresh_count++;
          end
          slot_value[s] = value;
          if (live_count == 0) begin
            fwd_link[s]  = s;
            back_link[s] = s;
            head_slot    = s;
          end else begin
            tail = back_link[head_slot];
            fwd_link[s]          = head_slot;
            back_link[s]         = tail;
            fwd_link[tail]       = s;
            back_link[head_slot] = s;
          end
          cur_slot = s;
          live_count++;
        end
      end
      OP_DELETE: begin
        if (live_count != 0) begin
          s = cur_slot;
          if (live_count == 1) begin
            head_slot = '0;
          end else begin
            p = back_link[s];
            n = fwd_link[s];
            fwd_link[p]  = n;
            back_link[n] = p;
            if (s == head_slot) head_slot = n;
          end
          fwd_link[s] = free_head;
          free_head   = s;
          free_count++;
          live_count--;
          cur_slot = (live_count == 0) ? '0 : head_slot;
        end
      end
      OP_NEXT: begin
        if (live_count != 0) cur_slot = fwd_link[cur_slot];
      end
      OP_PREV: begin
        if (live_count != 0) cur_slot = back_link[cur_slot];
      end
      OP_READ: begin
        if (live_count == 0) st = STATUS_READ_EMPTY;
      end
      OP_CLEAR: begin
        clear_list();
      end
      default: begin
      end
    endcase
    rep.cursor_value  = (live_count == 0) ? '0 : slot_value[cur_slot];
    rep.list_empty    = (live_count == 0);
    rep.status        = st;
    rep.element_count = live_count;
    return rep;
  endfunction

  task automatic compare_field(string field, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    list_report_t want;
    if (!rst_n) begin
      clear_list();
      pending_reports.delete();
    end else begin
      if (out_valid) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with nothing pending");
          errors++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("cursor_value", want.cursor_value, out_cursor_value);
          compare_field("list_empty", want.list_empty, out_list_empty);
          compare_field("status", want.status, out_status);
          compare_field("element_count", want.element_count, out_element_count);
        end
      end
      if (start && !busy) begin
        pending_reports.push_back(apply_list_op(in_opcode, in_element_value));
      end
    end
    fail_count  <= errors;
    outstanding <= pending_reports.size();
  end

endmodule

// ----- bench/circular_list_with_cursor_tb.sv -----
module circular_list_with_cursor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cll_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_A = CMD_NOP;
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

  localparam int SLOTS        = CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  localparam int MODE_GROW     = 0;
  localparam int MODE_BALANCED = 1;
  localparam int MODE_SHRINK   = 2;

  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [OPCODE_W-1:0]         in_opcode = '0;
  logic signed [VALUE_W-1:0]   in_element_value = '0;
  logic                        busy;
  logic                        out_valid;
  logic signed [VALUE_W-1:0]   out_cursor_value;
  logic                        out_list_empty;
  logic [STATUS_W-1:0]         out_status;
  logic [COUNT_OUT_W-1:0]      out_element_count;
  int unsigned                 fail_count;
  int unsigned                 outstanding;

  bit          idle_bursts = 1'b0;
  int unsigned cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_list_with_cursor u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_cursor_value  (out_cursor_value),
    .out_list_empty    (out_list_empty),
    .out_status        (out_status),
    .out_element_count (out_element_count)
  );

  cll_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_cursor_value  (out_cursor_value),
    .out_list_empty    (out_list_empty),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // start stays high across back-to-back transfers; it drops only for a gap
  task automatic issue(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value);
    start            <= 1'b1;
    in_opcode        <= op;
    in_element_value <= value;
    do @(posedge clk); while (busy);
    if (idle_bursts && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(int mode);
    int r;
    int push_pct;
    int del_pct;
    case (mode)
      MODE_GROW:     begin push_pct = 60; del_pct = 10; end
      MODE_BALANCED: begin push_pct = 35; del_pct = 20; end
      default:       begin push_pct = 15; del_pct = 45; end
    endcase
    r = $urandom_range(99);
    if (r < 2) return OP_CLEAR;
    if (r < 4) return r[0] ? OP_SPARE_B : OP_SPARE_A;
    if (r < 4 + push_pct) return OP_PUSH;
    if (r < 4 + push_pct + del_pct) return OP_DELETE;
    case (r % 3)
      0:       return OP_NEXT;
      1:       return OP_PREV;
      default: return OP_READ;
    endcase
  endfunction

  task automatic random_moves(int unsigned n);
    repeat (n) issue($urandom_range(1) ? OP_NEXT : OP_PREV, pick_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    issue(OP_READ, '0);
    issue(OP_DELETE, '0);
    issue(OP_NEXT, '0);
    issue(OP_PREV, '0);
    issue(OP_SPARE_A, '0);
    issue(OP_SPARE_B, VAL_ONES);
    // value extremes; cursor follows the tail
    issue(OP_PUSH, VAL_MAX);
    issue(OP_PUSH, VAL_MIN);
    issue(OP_PUSH, '0);
    issue(OP_PUSH, VAL_ONES);
    issue(OP_PUSH, 32'h5A5A_A5A5);
    issue(OP_READ, '0);
    issue(OP_NEXT, '0);
    issue(OP_DELETE, '0);
    issue(OP_PREV, '0);
    issue(OP_DELETE, '0);
    issue(OP_PUSH, 32'h1234_5678);
    issue(OP_READ, '0);
    issue(OP_SPARE_A, '0);
    issue(OP_SPARE_B, '0);
    issue(OP_CLEAR, '0);
    issue(OP_READ, '0);
    issue(OP_PUSH, 32'hA5A5_5A5A);
    issue(OP_DELETE, '0);
    issue(OP_READ, '0);
    wait_drained();

    // fill to capacity, then refused pushes and churn while full
    idle_bursts = 1'b1;
    issue(OP_CLEAR, '0);
    for (int i = 0; i < SLOTS; i++) begin
      issue(OP_PUSH, pick_value());
      if ($urandom_range(3) == 0) random_moves(1);
    end
    repeat (3) issue(OP_PUSH, pick_value());
    issue(OP_READ, '0);
    repeat (20) begin
      random_moves($urandom_range(3));
      issue(OP_DELETE, '0);
      issue(OP_PUSH, pick_value());
      issue(OP_PUSH, pick_value());
    end
    wait_drained();

    for (int seg = 0; seg < 8; seg++) begin
      int unsigned len;
      int mode;
      len = $urandom_range(90, 40);
      mode = $urandom_range(MODE_SHRINK, MODE_GROW);
      idle_bursts = $urandom_range(2) != 0;
      repeat (len) issue(pick_op(mode), pick_value());
      if ($urandom_range(2) == 0) wait_drained();
    end

    idle_bursts = 1'b0;
    repeat (150) issue(pick_op(MODE_BALANCED), pick_value());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cll_pkg.sv
rtl/cll_front.sv
rtl/cll_queue.sv
rtl/cll_back.sv
rtl/circular_list_with_cursor.sv
bench/cll_result_checker.sv
bench/circular_list_with_cursor_tb.sv
